[design/m65_pkg.sv]
// Shared types, operation codes and constants for the 6502 execute unit.
package m65_pkg;

    // Operation codes carried in the mode field.
    localparam logic [5:0] MD_JMP = 6'd0;
    localparam logic [5:0] MD_BRK = 6'd1;
    localparam logic [5:0] MD_SEI = 6'd2;
    localparam logic [5:0] MD_SEC = 6'd3;
    localparam logic [5:0] MD_SED = 6'd4;
    localparam logic [5:0] MD_CLC = 6'd5;
    localparam logic [5:0] MD_CLI = 6'd6;
    localparam logic [5:0] MD_CLV = 6'd7;
    localparam logic [5:0] MD_CLD = 6'd8;
    localparam logic [5:0] MD_LDA = 6'd9;
    localparam logic [5:0] MD_LDX = 6'd10;
    localparam logic [5:0] MD_LDY = 6'd11;
    localparam logic [5:0] MD_STA = 6'd12;
    localparam logic [5:0] MD_STX = 6'd13;
    localparam logic [5:0] MD_STY = 6'd14;
    localparam logic [5:0] MD_AND = 6'd15;
    localparam logic [5:0] MD_BEQ = 6'd16;
    localparam logic [5:0] MD_BCS = 6'd17;
    localparam logic [5:0] MD_JSR = 6'd18;
    localparam logic [5:0] MD_DEC = 6'd19;
    localparam logic [5:0] MD_DEX = 6'd20;
    localparam logic [5:0] MD_DEY = 6'd21;
    localparam logic [5:0] MD_TAX = 6'd22;
    localparam logic [5:0] MD_TAY = 6'd23;
    localparam logic [5:0] MD_TSX = 6'd24;
    localparam logic [5:0] MD_TXA = 6'd25;
    localparam logic [5:0] MD_TXS = 6'd26;
    localparam logic [5:0] MD_TYA = 6'd27;
    localparam logic [5:0] MD_BIT = 6'd28;
    localparam logic [5:0] MD_BPL = 6'd29;
    localparam logic [5:0] MD_BNE = 6'd30;
    localparam logic [5:0] MD_CMP = 6'd31;
    localparam logic [5:0] MD_CPY = 6'd32;
    localparam logic [5:0] MD_CPX = 6'd33;
    localparam logic [5:0] MD_ORA = 6'd34;
    localparam logic [5:0] MD_PHA = 6'd35;
    localparam logic [5:0] MD_PHP = 6'd36;
    localparam logic [5:0] MD_PLA = 6'd37;
    localparam logic [5:0] MD_PLP = 6'd38;
    localparam logic [5:0] MD_INC = 6'd39;
    localparam logic [5:0] MD_INX = 6'd40;
    localparam logic [5:0] MD_INY = 6'd41;
    localparam logic [5:0] MD_ROL = 6'd42;
    localparam logic [5:0] MD_ROR = 6'd43;
    localparam logic [5:0] MD_RTI = 6'd44;
    localparam logic [5:0] MD_RTS = 6'd45;
    localparam logic [5:0] MD_ADC = 6'd46;
    localparam logic [5:0] MD_SBC = 6'd47;
    localparam logic [5:0] MD_LSR = 6'd48;
    localparam logic [5:0] MD_ASL = 6'd49;
    localparam logic [5:0] MD_BCC = 6'd50;
    localparam logic [5:0] MD_BMI = 6'd51;
    localparam logic [5:0] MD_EOR = 6'd52;
    localparam logic [5:0] MD_NOP = 6'd53;
    localparam logic [5:0] MD_BVC = 6'd54;
    localparam logic [5:0] MD_BVS = 6'd55;
    localparam logic [5:0] MD_NMI = 6'd56;

    // Status flag bits.
    localparam logic [7:0] FL_C = 8'h01;
    localparam logic [7:0] FL_Z = 8'h02;
    localparam logic [7:0] FL_I = 8'h04;
    localparam logic [7:0] FL_D = 8'h08;
    localparam logic [7:0] FL_B = 8'h10;
    localparam logic [7:0] FL_U = 8'h20;
    localparam logic [7:0] FL_V = 8'h40;
    localparam logic [7:0] FL_N = 8'h80;

    // Reset values and fixed addresses.
    localparam logic [7:0] SP_RESET    = 8'hFD;
    localparam logic [7:0] FLAGS_RESET = 8'h24;
    localparam logic [7:0] STACK_PAGE  = 8'h01;
    localparam int STACK_DEPTH_DEF     = 256;
    localparam int QUEUE_DEPTH         = 2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NMI_VECTOR = 2'd0;
    localparam logic [1:0] CFG_BRK_VECTOR = 2'd1;

    // One classified item as it travels from the front to the back.
    typedef struct packed {
        logic [5:0]        mode;
        logic [7:0]        operand;
        logic [15:0]       effective_address;
        logic signed [7:0] branch_offset;
        logic              accumulator_mode;
        logic [15:0]       program_counter;
        logic [1:0]        pull_count;
        logic              hint;
    } queue_item_t;

    // Handshake between the queue and the back end.
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

[design/mos6502_execute_unit.sv]
// Top level of the 6502 execute unit: front end, item queue and back end.
//
// Input channel s_*: one decoded operation per item (valid/ready). The front
// end classifies it and places it in a two-entry queue, so items are taken
// while the back end is busy or the result side is stalled.
// Result channel m_*: one result per bus write (up to three for BRK/NMI), or
// one result without a write; m_last marks the final result of an item.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 NMI vector, 1 BRK vector) in the same cycle.
// Sequence: an item is executed into the state registers and write buffer,
// then one result per bus write is registered on the result channel. Stack
// pulls first read the bytes one at a time through the single read port of
// the stack page memory (PLA/PLP one byte, RTS two, RTI three). A new item
// is taken only after the last result of the previous one is registered.
// Reset clears A, X, Y, sets SP to 0xFD and flags to 0x24, and marks every
// stack page entry as zero at once through per-entry valid bits.
// While the receiver stalls the result is held; the queue keeps accepting
// until full.
module mos6502_execute_unit
    import m65_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [5:0]        s_mode,
    input  logic [7:0]        s_operand,
    input  logic [15:0]       s_effective_address,
    input  logic signed [7:0] s_branch_offset,
    input  logic              s_accumulator_mode,
    input  logic [15:0]       s_program_counter,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_write_enable,
    output logic [15:0]       m_write_address,
    output logic [7:0]        m_write_data,
    output logic [15:0]       m_next_pc,
    output logic [7:0]        m_reg_a,
    output logic [7:0]        m_reg_x,
    output logic [7:0]        m_reg_y,
    output logic [7:0]        m_stack_ptr,
    output logic [7:0]        m_status_flags,
    output logic [2:0]        m_extra_cycles,
    output logic              m_page_cross_hint,
    output logic              m_last
);

    queue_item_t front_item, q_item;
    logic        front_valid, front_ready;
    hs_t         q_hs, q_pop;

    m65_front u_front (
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_operand           (s_operand),
        .s_effective_address (s_effective_address),
        .s_branch_offset     (s_branch_offset),
        .s_accumulator_mode  (s_accumulator_mode),
        .s_program_counter   (s_program_counter),
        .item                (front_item),
        .item_valid          (front_valid),
        .item_ready          (front_ready)
    );

    m65_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_item      (front_item),
        .in_valid     (front_valid),
        .in_ready     (front_ready),
        .out_item     (q_item),
        .out_hs_valid (q_hs),
        .out_hs_ready (q_pop)
    );

    m65_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .q_item            (q_item),
        .q_hs              (q_hs),
        .q_pop             (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_write_enable    (m_write_enable),
        .m_write_address   (m_write_address),
        .m_write_data      (m_write_data),
        .m_next_pc         (m_next_pc),
        .m_reg_a           (m_reg_a),
        .m_reg_x           (m_reg_x),
        .m_reg_y           (m_reg_y),
        .m_stack_ptr       (m_stack_ptr),
        .m_status_flags    (m_status_flags),
        .m_extra_cycles    (m_extra_cycles),
        .m_page_cross_hint (m_page_cross_hint),
        .m_last            (m_last)
    );

`ifndef SYNTHESIS
    // A result without a bus write carries a zero address and data.
    a_nowrite_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_write_address == 16'h0000 && m_write_data == 8'h00)
        else $error("result without write has nonzero address or data");

    // A result without a write is always the only one of its item.
    a_nowrite_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_last)
        else $error("result without write is not last");

    // Interrupt entry always comes with stack writes.
    a_irq_writes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_extra_cycles == 3'd7 |-> m_write_enable)
        else $error("interrupt result without a write");
`endif

endmodule

[design/m65_front.sv]
// Front end: takes input items, maps unknown codes and classifies stack pulls and hints.
module m65_front
    import m65_pkg::*;
(
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [5:0]        s_mode,
    input  logic [7:0]        s_operand,
    input  logic [15:0]       s_effective_address,
    input  logic signed [7:0] s_branch_offset,
    input  logic              s_accumulator_mode,
    input  logic [15:0]       s_program_counter,
    output queue_item_t       item,
    output logic              item_valid,
    input  logic              item_ready
);

    logic [5:0] mode_mapped;

    // Codes beyond the interrupt behave as a no-operation.
    assign mode_mapped = (s_mode > MD_NMI) ? MD_NOP : s_mode;

    always_comb begin
        item.mode              = mode_mapped;
        item.operand           = s_operand;
        item.effective_address = s_effective_address;
        item.branch_offset     = s_branch_offset;
        item.accumulator_mode  = s_accumulator_mode;
        item.program_counter   = s_program_counter;
        // Number of stack bytes the back end must read before executing.
        unique case (mode_mapped)
            MD_PLA, MD_PLP: item.pull_count = 2'd1;
            MD_RTS:         item.pull_count = 2'd2;
            MD_RTI:         item.pull_count = 2'd3;
            default:        item.pull_count = 2'd0;
        endcase
        // Operations that may take an addressing page-cross cycle.
        unique case (mode_mapped)
            MD_LDA, MD_LDX, MD_LDY, MD_AND, MD_ORA, MD_EOR,
            MD_CMP, MD_ADC, MD_SBC: item.hint = 1'b1;
            default:                item.hint = 1'b0;
        endcase
    end

    assign item_valid = s_valid;
    assign s_ready    = item_ready;

endmodule

[design/m65_queue.sv]
// Short item queue between the front end and the back end.
module m65_queue
    import m65_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  queue_item_t in_item,
    input  logic        in_valid,
    output logic        in_ready,
    output queue_item_t out_item,
    output hs_t         out_hs_valid,
    input  hs_t         out_hs_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t       store_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready           = (count_reg != CNT_W'(DEPTH));
    assign out_hs_valid.valid = (count_reg != '0);
    assign out_hs_valid.ready = in_ready;
    assign out_item           = store_reg[rptr_reg];
    assign push               = in_valid && in_ready;
    assign pop                = out_hs_valid.valid && out_hs_ready.ready;

    // Storage is written at the write pointer; no reset needed.
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wptr_reg] <= in_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/m65_back.sv]
// Back end: register file, stack page memory, instruction execution and result register.
module m65_back
    import m65_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  queue_item_t q_item,
    input  hs_t         q_hs,
    output hs_t         q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_enable,
    output logic [15:0] m_write_address,
    output logic [7:0]  m_write_data,
    output logic [15:0] m_next_pc,
    output logic [7:0]  m_reg_a,
    output logic [7:0]  m_reg_x,
    output logic [7:0]  m_reg_y,
    output logic [7:0]  m_stack_ptr,
    output logic [7:0]  m_status_flags,
    output logic [2:0]  m_extra_cycles,
    output logic        m_page_cross_hint,
    output logic        m_last
);

    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {ST_IDLE, ST_PULL, ST_PULLEX, ST_EMIT} state_t;

    state_t      state_reg;
    logic [7:0]  a_reg, x_reg, y_reg, sp_reg, p_reg;
    logic [15:0] nmi_vec_reg, brk_vec_reg;
    queue_item_t cur_reg;
    logic [1:0]  rcnt_reg;
    logic [7:0]  pull_reg [3];
    logic [15:0] wbuf_addr_reg [3];
    logic [7:0]  wbuf_data_reg [3];
    logic [1:0]  wcnt_reg, eidx_reg;
    logic [15:0] res_pc_reg;
    logic [2:0]  res_cyc_reg;
    logic        res_hint_reg;

    // Stack page memory with one valid bit per entry.
    logic [7:0]       stack_mem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] stack_vld_reg;
    logic [IDX_W-1:0] rd_idx, wr_idx;
    logic [7:0]       rd_data_reg;
    logic             rd_vld_reg;
    logic [7:0]       pulled;
    logic             mem_we;
    logic [7:0]       rd_sp;

    // Execution datapath.
    queue_item_t ex_item;
    logic        ex_go, out_free, emit_fire, emit_last;
    logic [7:0]  a_next, x_next, y_next, sp_next, p_next;
    logic [15:0] pc_next;
    logic [2:0]  cyc_next;
    logic [1:0]  wcnt_next;
    logic [15:0] wa_next [3];
    logic [7:0]  wd_next [3];
    logic [15:0] br_tgt, pc_inc, pc_dec, rts_pc;
    logic [2:0]  br_cyc;
    logic        br_take;
    logic [7:0]  shin, shv, incv, decv, cmp_reg, push_p;
    logic [8:0]  sum9, dif9, cmp9;
    logic        cin;

    assign out_free  = !m_valid || m_ready;
    assign emit_fire = (state_reg == ST_EMIT) && out_free;
    assign emit_last = (wcnt_reg == 2'd0) || (eidx_reg == wcnt_reg - 2'd1);
    assign ex_go     = ((state_reg == ST_IDLE) && q_hs.valid && (q_item.pull_count == 2'd0))
                       || (state_reg == ST_PULLEX);
    assign ex_item   = (state_reg == ST_PULLEX) ? cur_reg : q_item;

    assign q_pop.ready = (state_reg == ST_IDLE);
    assign q_pop.valid = q_hs.valid && (state_reg == ST_IDLE);

    // Read address walks up from the stack pointer, one byte a cycle.
    assign rd_sp  = (state_reg == ST_PULL) ? (sp_reg + {6'd0, rcnt_reg} + 8'd2)
                                           : (sp_reg + 8'd1);
    assign rd_idx = rd_sp[IDX_W-1:0];
    assign wr_idx = wbuf_addr_reg[eidx_reg][IDX_W-1:0];
    assign mem_we = emit_fire && (wcnt_reg != 2'd0)
                    && (wbuf_addr_reg[eidx_reg][15:8] == STACK_PAGE);
    assign pulled = rd_vld_reg ? rd_data_reg : 8'h00;

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[wr_idx] <= wbuf_data_reg[eidx_reg];
        end
        rd_data_reg <= stack_mem[rd_idx];
    end

    // Valid bits; an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stack_vld_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end else begin
            if (mem_we) begin
                stack_vld_reg[wr_idx] <= 1'b1;
            end
            rd_vld_reg <= stack_vld_reg[rd_idx];
        end
    end

    // Shared arithmetic terms.
    always_comb begin
        cin     = p_reg[0];
        br_tgt  = ex_item.program_counter
                  + {{8{ex_item.branch_offset[7]}}, ex_item.branch_offset};
        br_cyc  = (br_tgt[15:8] != ex_item.program_counter[15:8]) ? 3'd2 : 3'd1;
        pc_inc  = ex_item.program_counter + 16'd1;
        pc_dec  = ex_item.program_counter - 16'd1;
        rts_pc  = {pull_reg[1], pull_reg[0]} + 16'd1;
        shin    = ex_item.accumulator_mode ? a_reg : ex_item.operand;
        incv    = ex_item.operand + 8'd1;
        decv    = ex_item.operand - 8'd1;
        sum9    = {1'b0, a_reg} + {1'b0, ex_item.operand} + {8'd0, cin};
        dif9    = {1'b0, a_reg} - {1'b0, ex_item.operand} - {8'd0, !cin};
        push_p  = p_reg | FL_U | ((ex_item.mode == MD_BRK) ? FL_B : 8'h00);
        unique case (ex_item.mode)
            MD_CPX:  cmp_reg = x_reg;
            MD_CPY:  cmp_reg = y_reg;
            default: cmp_reg = a_reg;
        endcase
        cmp9 = {1'b0, cmp_reg} - {1'b0, ex_item.operand};
        unique case (ex_item.mode)
            MD_ROL:  shv = {shin[6:0], cin};
            MD_ROR:  shv = {cin, shin[7:1]};
            MD_LSR:  shv = {1'b0, shin[7:1]};
            default: shv = {shin[6:0], 1'b0};
        endcase
    end

    // Instruction execution.
    always_comb begin
        a_next    = a_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        sp_next   = sp_reg;
        p_next    = p_reg;
        pc_next   = ex_item.program_counter;
        cyc_next  = 3'd0;
        wcnt_next = 2'd0;
        br_take   = 1'b0;
        for (int i = 0; i < 3; i++) begin
            wa_next[i] = 16'h0000;
            wd_next[i] = 8'h00;
        end
        unique case (ex_item.mode)
            MD_JMP: pc_next = ex_item.effective_address;
            MD_BRK, MD_NMI: begin
                if (ex_item.mode == MD_BRK) begin
                    wd_next[0] = pc_inc[15:8];
                    wd_next[1] = pc_inc[7:0];
                    pc_next    = brk_vec_reg;
                end else begin
                    wd_next[0] = ex_item.program_counter[15:8];
                    wd_next[1] = ex_item.program_counter[7:0];
                    pc_next    = nmi_vec_reg;
                end
                wd_next[2] = push_p;
                wa_next[0] = {STACK_PAGE, sp_reg};
                wa_next[1] = {STACK_PAGE, sp_reg - 8'd1};
                wa_next[2] = {STACK_PAGE, sp_reg - 8'd2};
                wcnt_next  = 2'd3;
                sp_next    = sp_reg - 8'd3;
                p_next     = p_reg | FL_I;
                cyc_next   = 3'd7;
            end
            MD_SEI: p_next = p_reg | FL_I;
            MD_SEC: p_next = p_reg | FL_C;
            MD_SED: p_next = p_reg | FL_D;
            MD_CLC: p_next = p_reg & ~FL_C;
            MD_CLI: p_next = p_reg & ~FL_I;
            MD_CLV: p_next = p_reg & ~FL_V;
            MD_CLD: p_next = p_reg & ~FL_D;
            MD_LDA: a_next = ex_item.operand;
            MD_LDX: x_next = ex_item.operand;
            MD_LDY: y_next = ex_item.operand;
            MD_STA, MD_STX, MD_STY: begin
                wa_next[0] = ex_item.effective_address;
                wd_next[0] = (ex_item.mode == MD_STA) ? a_reg :
                             (ex_item.mode == MD_STX) ? x_reg : y_reg;
                wcnt_next  = 2'd1;
            end
            MD_AND: a_next = a_reg & ex_item.operand;
            MD_ORA: a_next = a_reg | ex_item.operand;
            MD_EOR: a_next = a_reg ^ ex_item.operand;
            MD_BEQ: br_take = p_reg[1];
            MD_BNE: br_take = !p_reg[1];
            MD_BCS: br_take = p_reg[0];
            MD_BCC: br_take = !p_reg[0];
            MD_BMI: br_take = p_reg[7];
            MD_BPL: br_take = !p_reg[7];
            MD_BVS: br_take = p_reg[6];
            MD_BVC: br_take = !p_reg[6];
            MD_JSR: begin
                wa_next[0] = {STACK_PAGE, sp_reg};
                wa_next[1] = {STACK_PAGE, sp_reg - 8'd1};
                wd_next[0] = pc_dec[15:8];
                wd_next[1] = pc_dec[7:0];
                wcnt_next  = 2'd2;
                sp_next    = sp_reg - 8'd2;
                pc_next    = ex_item.effective_address;
            end
            MD_DEC, MD_INC: begin
                wa_next[0] = ex_item.effective_address;
                wd_next[0] = (ex_item.mode == MD_DEC) ? decv : incv;
                wcnt_next  = 2'd1;
            end
            MD_DEX: x_next = x_reg - 8'd1;
            MD_DEY: y_next = y_reg - 8'd1;
            MD_INX: x_next = x_reg + 8'd1;
            MD_INY: y_next = y_reg + 8'd1;
            MD_TAX: x_next = a_reg;
            MD_TAY: y_next = a_reg;
            MD_TSX: x_next = sp_reg;
            MD_TXA: a_next = x_reg;
            MD_TXS: sp_next = x_reg;
            MD_TYA: a_next = y_reg;
            MD_BIT: begin
                p_next[1] = ((a_reg & ex_item.operand) == 8'h00);
                p_next[7] = ex_item.operand[7];
                p_next[6] = ex_item.operand[6];
            end
            MD_CMP, MD_CPX, MD_CPY: begin
                p_next[0] = !cmp9[8];
                p_next[1] = (cmp9[7:0] == 8'h00);
                p_next[7] = cmp9[7];
            end
            MD_PHA, MD_PHP: begin
                wa_next[0] = {STACK_PAGE, sp_reg};
                wd_next[0] = (ex_item.mode == MD_PHA) ? a_reg : (p_reg | FL_B | FL_U);
                wcnt_next  = 2'd1;
                sp_next    = sp_reg - 8'd1;
                if (ex_item.mode == MD_PHP) begin
                    p_next = p_reg & ~(FL_B | FL_U);
                end
            end
            MD_PLA: begin
                a_next  = pull_reg[0];
                sp_next = sp_reg + 8'd1;
            end
            MD_PLP: begin
                p_next  = pull_reg[0] | FL_U;
                sp_next = sp_reg + 8'd1;
            end
            MD_ROL, MD_ROR, MD_LSR, MD_ASL: begin
                p_next[0] = ((ex_item.mode == MD_ROL) || (ex_item.mode == MD_ASL))
                            ? shin[7] : shin[0];
                p_next[1] = (shv == 8'h00);
                p_next[7] = shv[7];
                if (ex_item.accumulator_mode) begin
                    a_next = shv;
                end else begin
                    wa_next[0] = ex_item.effective_address;
                    wd_next[0] = shv;
                    wcnt_next  = 2'd1;
                end
            end
            MD_RTI: begin
                p_next  = pull_reg[0] & ~(FL_B | FL_U);
                pc_next = {pull_reg[2], pull_reg[1]};
                sp_next = sp_reg + 8'd3;
            end
            MD_RTS: begin
                pc_next = rts_pc;
                sp_next = sp_reg + 8'd2;
            end
            MD_ADC: begin
                a_next    = sum9[7:0];
                p_next[0] = sum9[8];
                p_next[6] = !(a_reg[7] ^ ex_item.operand[7]) & (a_reg[7] ^ sum9[7]);
            end
            MD_SBC: begin
                a_next    = dif9[7:0];
                p_next[0] = !dif9[8];
                p_next[6] = (a_reg[7] ^ dif9[7]) & !(ex_item.operand[7] ^ dif9[7]);
            end
            default: ;
        endcase
        // Value flags for register loads and arithmetic.
        unique case (ex_item.mode)
            MD_LDA, MD_AND, MD_ORA, MD_EOR, MD_TXA, MD_TYA, MD_PLA, MD_ADC, MD_SBC: begin
                p_next[1] = (a_next == 8'h00);
                p_next[7] = a_next[7];
            end
            MD_LDX, MD_DEX, MD_INX, MD_TAX, MD_TSX: begin
                p_next[1] = (x_next == 8'h00);
                p_next[7] = x_next[7];
            end
            MD_LDY, MD_DEY, MD_INY, MD_TAY: begin
                p_next[1] = (y_next == 8'h00);
                p_next[7] = y_next[7];
            end
            MD_DEC, MD_INC: begin
                p_next[1] = (wd_next[0] == 8'h00);
                p_next[7] = wd_next[0][7];
            end
            default: ;
        endcase
        if (br_take) begin
            pc_next  = br_tgt;
            cyc_next = br_cyc;
        end
    end

    // Sequencer, architectural state, write buffer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            a_reg       <= 8'h00;
            x_reg       <= 8'h00;
            y_reg       <= 8'h00;
            sp_reg      <= SP_RESET;
            p_reg       <= FLAGS_RESET;
            nmi_vec_reg <= 16'h0000;
            brk_vec_reg <= 16'h0000;
            m_valid     <= 1'b0;
            rcnt_reg    <= 2'd0;
            eidx_reg    <= 2'd0;
            wcnt_reg    <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_NMI_VECTOR) begin
                    nmi_vec_reg <= cfg_wdata;
                end else if (cfg_index == CFG_BRK_VECTOR) begin
                    brk_vec_reg <= cfg_wdata;
                end
            end
            // A taken result is dropped unless the next one replaces it.
            if (m_valid && m_ready && !emit_fire) begin
                m_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_hs.valid) begin
                        cur_reg  <= q_item;
                        rcnt_reg <= 2'd0;
                        if (q_item.pull_count != 2'd0) begin
                            state_reg <= ST_PULL;
                        end
                    end
                end
                ST_PULL: begin
                    pull_reg[rcnt_reg] <= pulled;
                    if (rcnt_reg == cur_reg.pull_count - 2'd1) begin
                        state_reg <= ST_PULLEX;
                    end else begin
                        rcnt_reg <= rcnt_reg + 2'd1;
                    end
                end
                ST_PULLEX: ;
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid           <= 1'b1;
                        m_write_enable    <= (wcnt_reg != 2'd0);
                        m_write_address   <= wbuf_addr_reg[eidx_reg];
                        m_write_data      <= wbuf_data_reg[eidx_reg];
                        m_next_pc         <= res_pc_reg;
                        m_reg_a           <= a_reg;
                        m_reg_x           <= x_reg;
                        m_reg_y           <= y_reg;
                        m_stack_ptr       <= sp_reg;
                        m_status_flags    <= p_reg;
                        m_extra_cycles    <= res_cyc_reg;
                        m_page_cross_hint <= res_hint_reg;
                        m_last            <= emit_last;
                        eidx_reg          <= eidx_reg + 2'd1;
                        if (emit_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (ex_go) begin
                a_reg        <= a_next;
                x_reg        <= x_next;
                y_reg        <= y_next;
                sp_reg       <= sp_next;
                p_reg        <= p_next;
                res_pc_reg   <= pc_next;
                res_cyc_reg  <= cyc_next;
                res_hint_reg <= ex_item.hint;
                wcnt_reg     <= wcnt_next;
                eidx_reg     <= 2'd0;
                for (int i = 0; i < 3; i++) begin
                    wbuf_addr_reg[i] <= wa_next[i];
                    wbuf_data_reg[i] <= wd_next[i];
                end
                state_reg    <= ST_EMIT;
            end
        end
    end

endmodule
